@@ rtl/core/mbq_pkg.sv @@
// Shared sizes, register codes and types for the multichannel biquad filter.
`timescale 1ns / 1ps

package mbq_pkg;

    // Block sizing
    localparam int NUM_CHANNELS = 2;
    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 32;
    localparam int COEF_FRAC    = COEF_BITS - 4;
    localparam int NUM_COEFS    = 5;

    // Derived widths
    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PROD_W  = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W   = PROD_W + 3;
    localparam int IDX_W   = 3;

    // Reset value of the leading feed-forward coefficient: 1.0
    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        IDX_FF0 = 3'd0,
        IDX_FF1 = 3'd1,
        IDX_FF2 = 3'd2,
        IDX_FB1 = 3'd3,
        IDX_FB2 = 3'd4
    } t_cfg_idx;

    // Normalized coefficient set
    typedef struct packed {
        logic [COEF_BITS-1:0] ff0;
        logic [COEF_BITS-1:0] ff1;
        logic [COEF_BITS-1:0] ff2;
        logic [COEF_BITS-1:0] fb1;
        logic [COEF_BITS-1:0] fb2;
    } t_coefs;

    // Delay taps of one channel
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x1;
        logic [SAMPLE_BITS-1:0] x2;
        logic [SAMPLE_BITS-1:0] y1;
        logic [SAMPLE_BITS-1:0] y2;
    } t_taps;

    // Delay-line update request
    typedef struct packed {
        logic                   we;
        logic [CH_W-1:0]        ch;
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
    } t_tap_wr;

endpackage

@@ rtl/core/mbq_coef.sv @@
// Coefficient register file written through the configuration port.
`timescale 1ns / 1ps

module mbq_coef (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mbq_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [mbq_pkg::COEF_BITS-1:0] i_cfg_data,
    output mbq_pkg::t_coefs               o_coefs
);

    mbq_pkg::t_coefs r_coefs;

    // Load the addressed coefficient; drop writes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.ff0 <= mbq_pkg::COEF_ONE;
            r_coefs.ff1 <= '0;
            r_coefs.ff2 <= '0;
            r_coefs.fb1 <= '0;
            r_coefs.fb2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mbq_pkg::IDX_FF0: r_coefs.ff0 <= i_cfg_data;
                mbq_pkg::IDX_FF1: r_coefs.ff1 <= i_cfg_data;
                mbq_pkg::IDX_FF2: r_coefs.ff2 <= i_cfg_data;
                mbq_pkg::IDX_FB1: r_coefs.fb1 <= i_cfg_data;
                mbq_pkg::IDX_FB2: r_coefs.fb2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

@@ rtl/core/mbq_state.sv @@
// Per-channel delay lines holding the last two inputs and outputs.
`timescale 1ns / 1ps

module mbq_state (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [mbq_pkg::CH_W-1:0] i_rd_ch,
    output mbq_pkg::t_taps           o_taps,
    input  mbq_pkg::t_tap_wr         i_wr
);

    mbq_pkg::t_taps r_taps [mbq_pkg::NUM_CHANNELS];

    // Shift the written channel's delays; clear all channels on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mbq_pkg::NUM_CHANNELS; i++) begin
                r_taps[i] <= '0;
            end
        end else if (i_wr.we) begin
            r_taps[i_wr.ch].x2 <= r_taps[i_wr.ch].x1;
            r_taps[i_wr.ch].x1 <= i_wr.x;
            r_taps[i_wr.ch].y2 <= r_taps[i_wr.ch].y1;
            r_taps[i_wr.ch].y1 <= i_wr.y;
        end
    end

    // Select the taps of the channel in the input register
    assign o_taps = r_taps[i_rd_ch];

endmodule

@@ rtl/core/mbq_mac.sv @@
// Five-term multiply-accumulate with round-to-nearest and saturation.
`timescale 1ns / 1ps

module mbq_mac (
    input  logic [mbq_pkg::SAMPLE_BITS-1:0] i_x,
    input  mbq_pkg::t_taps                  i_taps,
    input  mbq_pkg::t_coefs                 i_coefs,
    output logic [mbq_pkg::SAMPLE_BITS-1:0] o_y
);

    localparam int SB   = mbq_pkg::SAMPLE_BITS;
    localparam int PW   = mbq_pkg::PROD_W;
    localparam int AW   = mbq_pkg::ACC_W;
    localparam int FR   = mbq_pkg::COEF_FRAC;
    localparam logic [AW-1:0] HALF_LSB = AW'(1) << (FR - 1);

    logic signed [PW-1:0] p_ff0, p_ff1, p_ff2, p_fb1, p_fb2;
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] acc_rnd;
    logic signed [AW-1:0] acc_sh;
    logic [AW-SB:0]       upper;

    // Products, each full width
    always_comb begin
        p_ff0 = $signed(i_x)         * $signed(i_coefs.ff0);
        p_ff1 = $signed(i_taps.x1)   * $signed(i_coefs.ff1);
        p_ff2 = $signed(i_taps.x2)   * $signed(i_coefs.ff2);
        p_fb1 = $signed(i_taps.y1)   * $signed(i_coefs.fb1);
        p_fb2 = $signed(i_taps.y2)   * $signed(i_coefs.fb2);
    end

    // Exact sum, add half an output LSB, then drop the coefficient fraction
    always_comb begin
        acc     = AW'(p_ff0) + AW'(p_ff1) + AW'(p_ff2) + AW'(p_fb1) + AW'(p_fb2);
        acc_rnd = acc + $signed(HALF_LSB);
        acc_sh  = acc_rnd >>> FR;
        upper   = acc_sh[AW-1:SB-1];
    end

    // Clamp to the sample range when the upper bits disagree with the sign
    always_comb begin
        if ((&upper) || !(|upper)) begin
            o_y = acc_sh[SB-1:0];
        end else if (acc_sh[AW-1]) begin
            o_y = {1'b1, {(SB-1){1'b0}}};
        end else begin
            o_y = {1'b0, {(SB-1){1'b1}}};
        end
    end

endmodule

@@ rtl/core/multichannel_biquad_df1_top.sv @@
// Top level of the multichannel Direct Form 1 biquad filter.
`timescale 1ns / 1ps

// Two-channel biquad, Direct Form 1, with one delay set per channel selected
// by tuser. Throughput is one sample per clock while the output is not
// stalled, back to back on any mix of channels. An accepted request is held
// in the input register and loaded into the result register as soon as that
// register is empty or its result is taken. Between the two sits the
// single multiply-accumulate stage: five parallel multipliers, an adder
// tree, rounding and saturation, with the channel's delay lines updated at
// the same edge that loads the result. Coefficients are signed Q4.28 and are
// to be written through the configuration port only while the filter is
// idle; the block itself does not enforce this.
module multichannel_biquad_df1_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration writes
    input  logic                          i_cfg_we,
    input  logic [mbq_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [mbq_pkg::COEF_BITS-1:0] i_cfg_data,
    // Input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [mbq_pkg::DATA_W-1:0]    i_s_tdata,   // sample_in
    input  logic [0:0]                    i_s_tuser,   // chan
    input  logic                          i_s_tlast,
    // Output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [mbq_pkg::DATA_W-1:0]    o_m_tdata,   // sample_out
    output logic [0:0]                    o_m_tuser,   // chan_out
    output logic                          o_m_tlast
);

    localparam int SB = mbq_pkg::SAMPLE_BITS;

    mbq_pkg::t_coefs  coefs;
    mbq_pkg::t_taps   taps;
    mbq_pkg::t_tap_wr tap_wr;

    logic                     r_in_valid;
    logic [SB-1:0]            r_x;
    logic                     r_chan;
    logic                     r_last;
    logic                     r_out_valid;
    logic [SB-1:0]            r_y;
    logic                     r_chan_out;
    logic                     r_last_out;

    logic                     n_in_valid;
    logic                     n_out_valid;
    logic                     advance;
    logic                     move;
    logic                     accept;
    logic [mbq_pkg::CH_W-1:0] ch_sel;
    logic [SB-1:0]            y;

    // Handshake: the result register frees when empty or taken
    always_comb begin
        advance     = !r_out_valid || i_m_tready;
        move        = r_in_valid && advance;
        o_s_tready  = !r_in_valid || move;
        accept      = i_s_tvalid && o_s_tready;
        n_in_valid  = accept || (r_in_valid && !move);
        n_out_valid = advance ? r_in_valid : r_out_valid;
    end

    // Map the channel tag onto a delay set
    assign ch_sel = (mbq_pkg::NUM_CHANNELS > 1) ? mbq_pkg::CH_W'(r_chan) : '0;

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture an accepted request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x    <= i_s_tdata[SB-1:0];
            r_chan <= i_s_tuser[0];
            r_last <= i_s_tlast;
        end
    end

    // Load the result when the input register advances
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_y        <= y;
            r_chan_out <= r_chan;
            r_last_out <= r_last;
        end
    end

    mbq_coef u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (coefs)
    );

    // Shift the channel's delays together with the result load
    always_comb begin
        tap_wr.we = move;
        tap_wr.ch = ch_sel;
        tap_wr.x  = r_x;
        tap_wr.y  = y;
    end

    mbq_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_ch (ch_sel),
        .o_taps  (taps),
        .i_wr    (tap_wr)
    );

    mbq_mac u_mac (
        .i_x     (r_x),
        .i_taps  (taps),
        .i_coefs (coefs),
        .o_y     (y)
    );

    // Drive the output stream, padding the sample to whole bytes
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = mbq_pkg::DATA_W'(r_y);
    assign o_m_tuser  = r_chan_out;
    assign o_m_tlast  = r_last_out;

`ifndef ASSERT_OFF
    // An item in the input register moves to the result register when it is free
    a_move_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_valid)
        else $error("input item advanced but result register is empty");

    // A stalled input item keeps its sample and channel
    a_stall_holds_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_x) && $stable(r_chan)))
        else $error("stalled input item lost or changed");

    // Input side backs up only when both registers are full and output stalls
    a_ready_low_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled without a full pipeline");

    // A new result carries the channel and flag of the item that produced it
    a_result_tags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> (r_chan_out == $past(r_chan) && r_last_out == $past(r_last)))
        else $error("result tags do not match the source item");
`endif

endmodule

@@ dv/tb_multichannel_biquad_df1_top.sv @@
// Self-checking testbench for the multichannel Direct Form 1 biquad filter.
`timescale 1ns / 1ps

module tb_multichannel_biquad_df1_top;

    localparam int IDLE_PCT        = 27;
    localparam int MAX_REPORTS     = 10;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int STEADY_ITEMS    = 100;
    localparam int STALL_ITEMS     = 40;

    typedef logic signed [mbq_pkg::SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [mbq_pkg::COEF_BITS-1:0]   t_coef;
    typedef t_coef                                  t_coef_set [mbq_pkg::NUM_COEFS];

    typedef struct packed {
        logic [mbq_pkg::SAMPLE_BITS-1:0] sample;
        logic [mbq_pkg::CH_W-1:0]        chan;
        logic                            last;
    } t_filt_result;

    typedef enum int {
        SET_STABLE,
        SET_FULL_RANDOM,
        SET_EXTREME,
        SET_PASSTHROUGH
    } t_coef_kind;

    localparam t_sample S_MAX = {1'b0, {(mbq_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam t_sample S_MIN = {1'b1, {(mbq_pkg::SAMPLE_BITS-1){1'b0}}};
    localparam t_coef   C_MAX = {1'b0, {(mbq_pkg::COEF_BITS-1){1'b1}}};
    localparam t_coef   C_MIN = {1'b1, {(mbq_pkg::COEF_BITS-1){1'b0}}};
    localparam t_coef   C_HALF = mbq_pkg::COEF_ONE >> 1;
    localparam longint  Y_MAX = (longint'(1) <<< (mbq_pkg::SAMPLE_BITS-1)) - 1;
    localparam longint  Y_MIN = -(longint'(1) <<< (mbq_pkg::SAMPLE_BITS-1));

    localparam logic [mbq_pkg::CH_W-1:0] CH_LEFT  = mbq_pkg::CH_W'(0);
    localparam logic [mbq_pkg::CH_W-1:0] CH_RIGHT = mbq_pkg::CH_W'(1);

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [mbq_pkg::IDX_W-1:0]       i_cfg_index;
    logic [mbq_pkg::COEF_BITS-1:0]   i_cfg_data;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [mbq_pkg::DATA_W-1:0]      i_s_tdata;     // sample_in
    logic [0:0]                      i_s_tuser;     // chan
    logic                            i_s_tlast;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [mbq_pkg::DATA_W-1:0]      o_m_tdata;     // sample_out
    logic [0:0]                      o_m_tuser;     // chan_out
    logic                            o_m_tlast;

    // Filter state as the block should hold it
    t_coef   coef_regs [mbq_pkg::NUM_COEFS];
    t_sample tap_x1 [mbq_pkg::NUM_CHANNELS];
    t_sample tap_x2 [mbq_pkg::NUM_CHANNELS];
    t_sample tap_y1 [mbq_pkg::NUM_CHANNELS];
    t_sample tap_y2 [mbq_pkg::NUM_CHANNELS];

    t_filt_result expected_samples [$];

    int mismatch_count  = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int settings_loaded = 0;
    int rx_hold_left    = 0;
    bit tx_steady       = 1'b0;
    bit rx_steady       = 1'b0;

    multichannel_biquad_df1_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Compute one filtered sample and advance that channel's delay taps
    function automatic t_filt_result filter_sample(t_sample x,
                                                   logic [mbq_pkg::CH_W-1:0] ch,
                                                   logic last);
        int unsigned  sel;
        longint       acc;
        longint       y;
        t_filt_result r;
        sel = ch % mbq_pkg::NUM_CHANNELS;
        acc = longint'(coef_regs[mbq_pkg::IDX_FF0]) * longint'(x)
            + longint'(coef_regs[mbq_pkg::IDX_FF1]) * longint'(tap_x1[sel])
            + longint'(coef_regs[mbq_pkg::IDX_FF2]) * longint'(tap_x2[sel])
            + longint'(coef_regs[mbq_pkg::IDX_FB1]) * longint'(tap_y1[sel])
            + longint'(coef_regs[mbq_pkg::IDX_FB2]) * longint'(tap_y2[sel]);
        // Round half up, then clamp to the sample range
        acc = acc + (longint'(1) <<< (mbq_pkg::COEF_FRAC - 1));
        y = acc >>> mbq_pkg::COEF_FRAC;
        if (y > Y_MAX) begin
            y = Y_MAX;
        end else if (y < Y_MIN) begin
            y = Y_MIN;
        end
        tap_x2[sel] = tap_x1[sel];
        tap_x1[sel] = x;
        tap_y2[sel] = tap_y1[sel];
        tap_y1[sel] = t_sample'(y);
        r.sample = y[mbq_pkg::SAMPLE_BITS-1:0];
        r.chan   = ch;
        r.last   = last;
        return r;
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: MISMATCH %s", $time, msg);
        end
    endfunction

    function automatic real unit_rand();
        return real'($urandom_range(1000000)) / 1.0e6;
    endfunction

    function automatic t_coef to_q428(real v);
        return t_coef'($rtoi(v * (2.0 ** mbq_pkg::COEF_FRAC)));
    endfunction

    // Mostly full-scale noise, with extremes and quiet passages mixed in
    function automatic t_sample rand_sample();
        case ($urandom_range(9))
            0: return S_MAX;
            1: return S_MIN;
            2, 3: return t_sample'(int'($urandom_range(2000)) - 1000);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_sample(input t_sample x, input logic [mbq_pkg::CH_W-1:0] ch,
                               input logic last);
        while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= mbq_pkg::DATA_W'($unsigned(x));
        i_s_tuser  <= ch;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) begin
            @(posedge i_clk);
        end
        expected_samples.push_back(filter_sample(x, ch, last));
        items_sent++;
    endtask

    // Drop valid and hold until every result is back and the pipeline is empty
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all five coefficients, then optionally every unused index
    task automatic load_coefs(input t_coef_set coefs, input bit with_strays);
        int k;
        for (k = 0; k < mbq_pkg::NUM_COEFS; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= mbq_pkg::IDX_W'(mbq_pkg::t_cfg_idx'(k));
            i_cfg_data  <= coefs[k];
            @(posedge i_clk);
            coef_regs[k] = coefs[k];
        end
        if (with_strays) begin
            for (k = mbq_pkg::NUM_COEFS; k < 2 ** mbq_pkg::IDX_W; k++) begin
                i_cfg_index <= mbq_pkg::IDX_W'(k);
                i_cfg_data  <= $urandom;
                @(posedge i_clk);
            end
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_loaded++;
    endtask

    task automatic pick_coefs(input t_coef_kind kind, output t_coef_set coefs);
        real radius;
        int  k;
        case (kind)
            SET_STABLE: begin
                // Complex pole pair inside the unit circle, random zeros
                radius = 0.1 + 0.89 * unit_rand();
                coefs[mbq_pkg::IDX_FF0] = to_q428(2.0 * unit_rand() - 1.0);
                coefs[mbq_pkg::IDX_FF1] = to_q428(2.0 * unit_rand() - 1.0);
                coefs[mbq_pkg::IDX_FF2] = to_q428(2.0 * unit_rand() - 1.0);
                coefs[mbq_pkg::IDX_FB1] = to_q428((4.0 * unit_rand() - 2.0) * radius);
                coefs[mbq_pkg::IDX_FB2] = to_q428(-radius * radius);
            end
            SET_FULL_RANDOM: begin
                for (k = 0; k < mbq_pkg::NUM_COEFS; k++) coefs[k] = t_coef'($urandom);
            end
            SET_EXTREME: begin
                for (k = 0; k < mbq_pkg::NUM_COEFS; k++) begin
                    case ($urandom_range(4))
                        0: coefs[k] = C_MAX;
                        1: coefs[k] = C_MIN;
                        2: coefs[k] = '0;
                        3: coefs[k] = mbq_pkg::COEF_ONE;
                        default: coefs[k] = '1;
                    endcase
                end
            end
            default: coefs = '{mbq_pkg::COEF_ONE, '0, '0, '0, '0};
        endcase
    endtask

    // Stereo-interleaved buffers most of the time, otherwise random channel mix
    task automatic stream_samples(input int count);
        int   n;
        int   buf_left;
        int   chan_idx;
        bit   stereo;
        logic last;
        stereo   = ($urandom_range(9) < 7);
        buf_left = 2 * $urandom_range(8, 1);
        chan_idx = 0;
        for (n = 0; n < count; n++) begin
            if (!stereo) begin
                chan_idx = $urandom_range(mbq_pkg::NUM_CHANNELS - 1);
            end
            buf_left--;
            last = stereo ? (buf_left == 0) : ($urandom_range(7) == 0);
            send_sample(rand_sample(), mbq_pkg::CH_W'(chan_idx), last);
            if (buf_left == 0) begin
                buf_left = 2 * $urandom_range(8, 1);
            end
            if (stereo) begin
                chan_idx = (chan_idx + 1) % mbq_pkg::NUM_CHANNELS;
            end
        end
    endtask

    // Reset coefficients pass samples straight through
    task automatic test_default_passthrough();
        send_sample(S_MAX, CH_LEFT, 1'b0);
        send_sample(S_MIN, CH_RIGHT, 1'b0);
        send_sample(t_sample'(0), CH_LEFT, 1'b1);
        send_sample(t_sample'(1), CH_RIGHT, 1'b0);
        send_sample(t_sample'(-1), CH_LEFT, 1'b0);
        send_sample(t_sample'(24'h555555), CH_LEFT, 1'b0);
        send_sample(t_sample'(24'hAAAAAA), CH_RIGHT, 1'b1);
        wait_for_results();
    endtask

    // Writes to unused indexes must leave the coefficients alone
    task automatic test_stray_writes();
        t_coef_set coefs;
        coefs = '{mbq_pkg::COEF_ONE, '0, '0, '0, '0};
        load_coefs(coefs, 1'b1);
        send_sample(t_sample'(12345), CH_LEFT, 1'b0);
        send_sample(t_sample'(-54321), CH_RIGHT, 1'b0);
        send_sample(S_MAX, CH_LEFT, 1'b1);
        wait_for_results();
    endtask

    // Gain of one half makes odd inputs land exactly on half an LSB
    task automatic test_rounding_ties();
        t_coef_set coefs;
        coefs = '{C_HALF, '0, '0, '0, '0};
        load_coefs(coefs, 1'b0);
        send_sample(t_sample'(1), CH_LEFT, 1'b0);
        send_sample(t_sample'(-1), CH_RIGHT, 1'b0);
        send_sample(t_sample'(3), CH_LEFT, 1'b0);
        send_sample(t_sample'(-3), CH_RIGHT, 1'b1);
        wait_for_results();
    endtask

    // Clamp at both ends; the clamped value must feed back
    task automatic test_saturation();
        t_coef_set coefs;
        coefs = '{C_MAX, '0, '0, C_MAX, '0};
        load_coefs(coefs, 1'b0);
        send_sample(S_MAX, CH_LEFT, 1'b0);
        send_sample(t_sample'(0), CH_LEFT, 1'b0);
        send_sample(S_MIN, CH_RIGHT, 1'b1);
        wait_for_results();
        coefs = '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN};
        load_coefs(coefs, 1'b0);
        send_sample(S_MAX, CH_LEFT, 1'b0);
        send_sample(S_MIN, CH_LEFT, 1'b0);
        send_sample(S_MIN, CH_RIGHT, 1'b1);
        wait_for_results();
    endtask

    // Impulses on one channel must not leak into the other's taps
    task automatic test_channel_isolation();
        t_coef_set coefs;
        coefs = '{mbq_pkg::COEF_ONE, C_HALF, -(C_HALF >>> 1), C_HALF, -(C_HALF >>> 1)};
        load_coefs(coefs, 1'b0);
        send_sample(S_MAX, CH_LEFT, 1'b0);
        send_sample(t_sample'(0), CH_RIGHT, 1'b0);
        send_sample(t_sample'(0), CH_LEFT, 1'b0);
        send_sample(S_MIN, CH_RIGHT, 1'b0);
        send_sample(t_sample'(0), CH_LEFT, 1'b1);
        wait_for_results();
    endtask

    // Back-to-back traffic with neither side idling
    task automatic test_steady_stream();
        t_coef_set coefs;
        pick_coefs(SET_STABLE, coefs);
        load_coefs(coefs, 1'b0);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        stream_samples(STEADY_ITEMS);
        wait_for_results();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Cycle through filter shapes, reloading only while idle
    task automatic test_random_filters();
        t_coef_set coefs;
        int        phase;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick_coefs(t_coef_kind'(phase % 4), coefs);
            load_coefs(coefs, 1'($urandom_range(1)));
            stream_samples(ITEMS_PER_PHASE);
            wait_for_results();
        end
    endtask

    // Long output stall while input keeps coming, so the block backs up
    task automatic test_output_stall();
        tx_steady    = 1'b1;
        rx_hold_left = HOLD_CYCLES;
        stream_samples(STALL_ITEMS);
        tx_steady = 1'b0;
        wait_for_results();
    endtask

    // Output ready: random idling, steady, or a counted hold-off
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                i_m_tready <= 1'b0;
                rx_hold_left--;
            end else if (rx_steady) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_filt_result want;
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            if (expected_samples.size() == 0) begin
                flag_mismatch($sformatf("result with none expected: sample %0d chan %0d",
                                        t_sample'(o_m_tdata[mbq_pkg::SAMPLE_BITS-1:0]),
                                        o_m_tuser));
            end else begin
                want = expected_samples.pop_front();
                results_checked++;
                if (o_m_tdata !== mbq_pkg::DATA_W'(want.sample)) begin
                    flag_mismatch($sformatf("sample: expected %0d, got %0d",
                                            t_sample'(want.sample),
                                            t_sample'(o_m_tdata[mbq_pkg::SAMPLE_BITS-1:0])));
                end
                if (o_m_tuser !== want.chan) begin
                    flag_mismatch($sformatf("chan: expected %0d, got %0d",
                                            want.chan, o_m_tuser));
                end
                if (o_m_tlast !== want.last) begin
                    flag_mismatch($sformatf("last: expected %0d, got %0d",
                                            want.last, o_m_tlast));
                end
            end
        end
    end

    // End the run if no handshake happens for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we
                    || !i_rst_n) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int ch;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= '0;
        i_s_tlast   <= 1'b0;
        coef_regs = '{mbq_pkg::COEF_ONE, '0, '0, '0, '0};
        for (ch = 0; ch < mbq_pkg::NUM_CHANNELS; ch++) begin
            tap_x1[ch] = '0;
            tap_x2[ch] = '0;
            tap_y1[ch] = '0;
            tap_y2[ch] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_passthrough();
        test_stray_writes();
        test_rounding_ties();
        test_saturation();
        test_channel_isolation();
        test_steady_stream();
        test_random_filters();
        test_output_stall();
        wait_for_results();

        if (expected_samples.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", expected_samples.size()));
        end
        $display("covered %0d samples on %0d channels over %0d coefficient settings",
                 items_sent, mbq_pkg::NUM_CHANNELS, settings_loaded);
        $display("checked %0d results, incl. ties, clamping, unused indexes, %0d-cycle stall",
                 results_checked, HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ multichannel_biquad_df1_top.f @@
rtl/core/mbq_pkg.sv
rtl/core/mbq_coef.sv
rtl/core/mbq_state.sv
rtl/core/mbq_mac.sv
rtl/core/multichannel_biquad_df1_top.sv
dv/tb_multichannel_biquad_df1_top.sv
